// ===== design/voc_pkg.sv =====
// ----------------------------------------------------------------------------
// voc_pkg
// Shared sizes, modes and state codes of the vector overlap combiner.
// ----------------------------------------------------------------------------
`default_nettype none

package voc_pkg;

  localparam int MaxItems  = 64;
  localparam int CntW      = $clog2(MaxItems + 1);
  localparam int AddrW     = $clog2(MaxItems);
  localparam int CompW     = 32;
  localparam int SumW      = CompW + $clog2(MaxItems);
  localparam int DotW      = CompW + SumW + 2;
  localparam int NrmW      = 2 * SumW + 2;
  localparam int NumChunks = 3;
  localparam int ChunkW    = (DotW + NumChunks - 1) / NumChunks;
  localparam int MagPW     = NumChunks * ChunkW;
  localparam int NumW      = MagPW + SumW;
  localparam int DivCntW   = $clog2(NumW);

  typedef enum logic [1:0] {
    MODE_MAX = 2'd0,
    MODE_MIN = 2'd1,
    MODE_AVG = 2'd2,
    MODE_SUM = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CLOSE,
    ST_NORM,
    ST_NCHK,
    ST_SCAN_RD,
    ST_SCAN_MUL,
    ST_SCAN_CMP,
    ST_PICK,
    ST_SCALE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// ===== design/voc_div.sv =====
// ----------------------------------------------------------------------------
// voc_div
// Restoring divider, one quotient bit per cycle, rounded to nearest with
// halves away from zero.
// ----------------------------------------------------------------------------
`default_nettype none

module voc_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [voc_pkg::NumW-1:0]  num_i,
  input  wire logic [voc_pkg::NrmW-1:0]  den_i,
  output logic      [voc_pkg::NumW:0]    quot_o,
  output logic                           done_o
);
  import voc_pkg::*;

  logic               busy_q, rnd_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [NumW-1:0]    n_q, q_q;
  logic [NrmW-1:0]    d_q, r_q;
  logic [NrmW:0]      rs, rsub;
  logic               take;

  assign rs   = {r_q, n_q[NumW-1]};
  assign rsub = rs - {1'b0, d_q};
  assign take = rs >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(NumW - 1)) begin
          busy_q <= 1'b0;
          rnd_q  <= 1'b1;
        end
      end else if (rnd_q) begin
        rnd_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= num_i;
      d_q <= den_i;
      r_q <= '0;
      q_q <= '0;
    end else if (busy_q) begin
      n_q <= {n_q[NumW-2:0], 1'b0};
      q_q <= {q_q[NumW-2:0], take};
      r_q <= take ? rsub[NrmW-1:0] : rs[NrmW-1:0];
    end else if (rnd_q) begin
      quot_o <= {1'b0, q_q} + ((({1'b0, r_q} << 1) >= {1'b0, d_q}) ? 1'b1 : 1'b0);
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== design/vector_overlap_combine.sv =====
// ----------------------------------------------------------------------------
// vector_overlap_combine
// Stores a run of Q16.16 vectors and gives one combined vector per run.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries one vector per transfer;
// last_vector_i closes the run. Each of the first MaxItems vectors is
// put in the vector memory and running sums; later ones set ovfl_q.
// After the closing transfer the input is held off while the result forms:
//   single vector or sum mode: straight to hand-off
//   average mode: each sum divided by the count in the serial divider
//   max/min mode: norm of the sums, then a scan (one memory read
//   and three multiplies per stored vector), then pick, scale, divide
//   and hand-off; a zero sum ends after the norm check
// The result goes into an output register (out_valid_o/out_ready_i); a
// waiting result does not block loading of the next run, only its output.
// overlap_mode is written via cfg_we_i/cfg_wdata_i; users must do so only
// while idle, not enforced by the block. Reset sets sum mode and clears
// count, sums, ovfl_q; memory needs no clearing as only this run is read.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_overlap_combine (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] vec_x_i,
  input  wire logic signed [31:0] vec_y_i,
  input  wire logic signed [31:0] vec_z_i,
  input  wire logic               last_vector_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      out_x_o,
  output logic signed [31:0]      out_y_o,
  output logic signed [31:0]      out_z_o,
  output logic                    degenerate_o,
  output logic                    overflowed_o
);
  import voc_pkg::*;

  state_e state_q, state_d;
  mode_e  mode_q;

  logic [CntW-1:0]        cnt_q;
  logic signed [SumW-1:0] sum_q [3];
  logic                   ovfl_q;
  logic                   out_valid_q;

  logic [3*CompW-1:0]     mem [MaxItems];
  logic [3*CompW-1:0]     rdata_q;

  logic [1:0]             comp_q, k_q;
  logic [CntW-1:0]        idx_q;
  logic signed [DotW-1:0] acc_q, best_q;
  logic [NrmW-1:0]        nrm_q;
  logic [MagPW-1:0]       mag_q;
  logic                   mneg_q, neg_q;
  logic [NumW-1:0]        num_q;
  logic [CompW-1:0]       res_q [3];
  logic                   ovf_q, degen_q;

  logic                   accept, wr_en, rd_en, div_start, emit;
  logic                   div_done;
  logic [NumW:0]          quot;
  logic [NumW-1:0]        div_num;
  logic [NrmW-1:0]        div_den;

  logic signed [CompW-1:0]      vsel;
  logic signed [SumW-1:0]       ssel;
  logic [SumW-1:0]              sabs;
  logic signed [CompW+SumW-1:0] pdot;
  logic signed [2*SumW-1:0]     psq;
  logic [ChunkW-1:0]            chunk;
  logic [ChunkW+SumW-1:0]       pchunk;
  logic signed [DotW-1:0]       bsel;
  logic                         better;
  logic [CompW-1:0]             qsat;
  logic                         qovf;

  function automatic logic [CompW:0] sat_sum(input logic signed [SumW-1:0] s);
    logic [CompW:0] r;
    if (s > $signed({{(SumW-CompW+1){1'b0}}, {(CompW-1){1'b1}}})) begin
      r = {1'b1, 1'b0, {(CompW-1){1'b1}}};
    end else if (s < -$signed({{(SumW-CompW){1'b0}}, 1'b1, {(CompW-1){1'b0}}})) begin
      r = {1'b1, 1'b1, {(CompW-1){1'b0}}};
    end else begin
      r = {1'b0, s[CompW-1:0]};
    end
    return r;
  endfunction

  // operand selection
  always_comb begin
    unique case (comp_q)
      2'd0:    begin vsel = rdata_q[CompW-1:0];         ssel = sum_q[0]; end
      2'd1:    begin vsel = rdata_q[2*CompW-1:CompW];   ssel = sum_q[1]; end
      default: begin vsel = rdata_q[3*CompW-1:2*CompW]; ssel = sum_q[2]; end
    endcase
    unique case (k_q)
      2'd0:    chunk = mag_q[ChunkW-1:0];
      2'd1:    chunk = mag_q[2*ChunkW-1:ChunkW];
      default: chunk = mag_q[3*ChunkW-1:2*ChunkW];
    endcase
  end

  assign sabs   = ssel[SumW-1] ? SumW'(-ssel) : ssel;
  assign pdot   = vsel * ssel;
  assign psq    = ssel * ssel;
  assign pchunk = chunk * sabs;
  assign better = (idx_q == '0) ||
                  ((mode_q == MODE_MAX) ? (best_q < acc_q) : (acc_q < best_q));
  assign bsel   = ((mode_q == MODE_MAX) && best_q[DotW-1]) ? '0 : best_q;

  always_comb begin
    qovf = 1'b0;
    if (neg_q) begin
      if (quot > (NumW+1)'({1'b1, {(CompW-1){1'b0}}})) begin
        qsat = {1'b1, {(CompW-1){1'b0}}};
        qovf = 1'b1;
      end else begin
        qsat = -quot[CompW-1:0];
      end
    end else begin
      if (quot > (NumW+1)'({(CompW-1){1'b1}})) begin
        qsat = {1'b0, {(CompW-1){1'b1}}};
        qovf = 1'b1;
      end else begin
        qsat = quot[CompW-1:0];
      end
    end
  end

  assign div_num = (mode_q == MODE_AVG) ? NumW'(sabs) : num_q;
  assign div_den = (mode_q == MODE_AVG) ? NrmW'(cnt_q) : nrm_q;

  voc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (quot),
    .done_o  (div_done)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:     if (accept && last_vector_i) state_d = ST_CLOSE;
      ST_CLOSE: begin
        if (cnt_q == CntW'(1) || mode_q == MODE_SUM) state_d = ST_EMIT;
        else if (mode_q == MODE_AVG)                 state_d = ST_DIV_GO;
        else                                         state_d = ST_NORM;
      end
      ST_NORM:     if (comp_q == 2'd2) state_d = ST_NCHK;
      ST_NCHK:     state_d = (nrm_q == '0) ? ST_EMIT : ST_SCAN_RD;
      ST_SCAN_RD:  state_d = ST_SCAN_MUL;
      ST_SCAN_MUL: if (comp_q == 2'd2) state_d = ST_SCAN_CMP;
      ST_SCAN_CMP: state_d = (idx_q + 1'b1 == cnt_q) ? ST_PICK : ST_SCAN_RD;
      ST_PICK:     state_d = ST_SCALE;
      ST_SCALE:    if (k_q == 2'(NumChunks - 1)) state_d = ST_DIV_GO;
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (comp_q == 2'd2)          state_d = ST_EMIT;
          else if (mode_q == MODE_AVG) state_d = ST_DIV_GO;
          else                         state_d = ST_SCALE;
        end
      end
      ST_EMIT:     if (!out_valid_q || out_ready_i) state_d = ST_LOAD;
      default:     state_d = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = (state_q == ST_LOAD);
    rd_en      = (state_q == ST_SCAN_RD);
    div_start  = (state_q == ST_DIV_GO);
    emit       = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  end

  assign accept = in_valid_i && in_ready_o;
  assign wr_en  = accept && (cnt_q < CntW'(MaxItems));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      mode_q      <= MODE_SUM;
      cnt_q       <= '0;
      sum_q[0]    <= '0;
      sum_q[1]    <= '0;
      sum_q[2]    <= '0;
      ovfl_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) mode_q <= mode_e'(cfg_wdata_i);
      if (wr_en) begin
        cnt_q    <= cnt_q + 1'b1;
        sum_q[0] <= sum_q[0] + {{(SumW-CompW){vec_x_i[CompW-1]}}, vec_x_i};
        sum_q[1] <= sum_q[1] + {{(SumW-CompW){vec_y_i[CompW-1]}}, vec_y_i};
        sum_q[2] <= sum_q[2] + {{(SumW-CompW){vec_z_i[CompW-1]}}, vec_z_i};
      end else if (accept) begin
        ovfl_q <= 1'b1;
      end
      if (emit) begin
        cnt_q       <= '0;
        sum_q[0]    <= '0;
        sum_q[1]    <= '0;
        sum_q[2]    <= '0;
        ovfl_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // vector memory
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[cnt_q[AddrW-1:0]] <= {vec_z_i, vec_y_i, vec_x_i};
    if (rd_en) rdata_q <= mem[idx_q[AddrW-1:0]];
  end

  // closing datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_CLOSE: begin
        logic [CompW:0] sx, sy, sz;
        sx = sat_sum(sum_q[0]);
        sy = sat_sum(sum_q[1]);
        sz = sat_sum(sum_q[2]);
        res_q[0] <= sx[CompW-1:0];
        res_q[1] <= sy[CompW-1:0];
        res_q[2] <= sz[CompW-1:0];
        ovf_q    <= ovfl_q |
                    ((mode_q == MODE_SUM) ? (sx[CompW] | sy[CompW] | sz[CompW]) : 1'b0);
        degen_q  <= 1'b0;
        comp_q   <= '0;
        k_q      <= '0;
        nrm_q    <= '0;
        num_q    <= '0;
        idx_q    <= '0;
        neg_q    <= 1'b0;
        mneg_q   <= 1'b0;
      end
      ST_NORM: begin
        nrm_q  <= nrm_q + {{(NrmW-2*SumW){1'b0}}, psq};
        comp_q <= comp_q + 1'b1;
      end
      ST_NCHK: begin
        degen_q  <= (nrm_q == '0);
        res_q[0] <= '0;
        res_q[1] <= '0;
        res_q[2] <= '0;
      end
      ST_SCAN_RD: begin
        acc_q  <= '0;
        comp_q <= '0;
      end
      ST_SCAN_MUL: begin
        acc_q  <= acc_q + {{(DotW-CompW-SumW){pdot[CompW+SumW-1]}}, pdot};
        comp_q <= comp_q + 1'b1;
      end
      ST_SCAN_CMP: begin
        if (better) best_q <= acc_q;
        idx_q <= idx_q + 1'b1;
      end
      ST_PICK: begin
        mneg_q <= bsel[DotW-1];
        mag_q  <= MagPW'(bsel[DotW-1] ? DotW'(-bsel) : bsel);
        comp_q <= '0;
        k_q    <= '0;
        num_q  <= '0;
      end
      ST_SCALE: begin
        num_q <= num_q + (NumW'(pchunk) << (ChunkW * k_q));
        k_q   <= k_q + 1'b1;
      end
      ST_DIV_GO: begin
        neg_q <= ssel[SumW-1] ^ ((mode_q == MODE_AVG) ? 1'b0 : mneg_q);
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          unique case (comp_q)
            2'd0:    res_q[0] <= qsat;
            2'd1:    res_q[1] <= qsat;
            default: res_q[2] <= qsat;
          endcase
          ovf_q  <= ovf_q | qovf;
          comp_q <= comp_q + 1'b1;
          k_q    <= '0;
          num_q  <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_x_o      <= res_q[0];
      out_y_o      <= res_q[1];
      out_z_o      <= res_q[2];
      degenerate_o <= degen_q;
      overflowed_o <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
